/* rtl/mpf_pkg.sv */
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared sizes, types and helpers of the two-dimensional peak finder.
// ----------------------------------------------------------------------------
package mpf_pkg;

  // Matrix limits and element width
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;
  localparam int unsigned DataW   = 32;

  // Derived storage sizes
  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned ColW  = $clog2(MaxCols);
  localparam int unsigned PtrW  = AddrW + 1;

  // Register and result field widths
  localparam int unsigned DimW     = 7;
  localparam int unsigned IterW    = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumRows = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNumCols = 1'b1;

  localparam logic [DimW-1:0] DimResetVal = DimW'(64);

  // Effective matrix dimensions, already clamped
  typedef struct packed {
    logic [DimW-1:0] rows;
    logic [DimW-1:0] cols;
  } dims_t;

  // Matrix store access request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Zero counts as one, anything above the limit counts as the limit
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] lim);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/mpf_ram.sv */
// ----------------------------------------------------------------------------
// mpf_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mpf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/mpf_ctrl.sv */
// ----------------------------------------------------------------------------
// mpf_ctrl
// Load sequencer and row-halving search engine around the matrix store.
// ----------------------------------------------------------------------------
module mpf_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [mpf_pkg::DataW-1:0]       element_value_i,
  input  logic                            last_element_i,
  input  mpf_pkg::dims_t                  dims_i,
  output mpf_pkg::mem_req_t               mem_req_o,
  input  logic [mpf_pkg::DataW-1:0]       mem_rdata_i,
  output logic                            done_o,
  output logic [mpf_pkg::RowW-1:0]        peak_row_o,
  output logic [mpf_pkg::ColW-1:0]        peak_col_o,
  output logic [mpf_pkg::IterW-1:0]       iteration_count_o
);
  import mpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MID,
    S_SCAN,
    S_LAST,
    S_UP,
    S_DN,
    S_DEC
  } state_e;

  state_e            state_q, state_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [RowW-1:0]   lo_q, lo_d;
  logic [RowW-1:0]   hi_q, hi_d;
  logic [RowW-1:0]   mid_q, mid_d;
  logic [AddrW-1:0]  base_q, base_d;
  logic [ColW-1:0]   col_q, col_d;
  logic              scan_vld_q, scan_vld_d;
  logic [ColW-1:0]   scan_col_q, scan_col_d;
  logic [DataW-1:0]  best_q, best_d;
  logic [ColW-1:0]   best_col_q, best_col_d;
  logic              up_win_q, up_win_d;
  logic [DataW-1:0]  win_q, win_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic              done_q, done_d;
  logic [RowW-1:0]   out_row_q, out_row_d;
  logic [ColW-1:0]   out_col_q, out_col_d;
  logic [IterW-1:0]  out_iter_q, out_iter_d;

  logic [2*DimW-1:0]    total;
  logic [RowW:0]        bound_sum;
  logic [RowW+DimW-1:0] base_prod;
  logic                 dn_win;

  assign total     = dims_i.rows * dims_i.cols;
  assign bound_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign base_prod = bound_sum[RowW:1] * dims_i.cols;
  assign dn_win    = ((DimW'(mid_q) + DimW'(1)) < dims_i.rows) && (mem_rdata_i > win_q);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    base_d     = base_q;
    col_d      = col_q;
    scan_vld_d = 1'b0;
    scan_col_d = scan_col_q;
    best_d     = best_q;
    best_col_d = best_col_q;
    up_win_d   = up_win_q;
    win_d      = win_q;
    iter_d     = iter_q;
    done_d     = 1'b0;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_iter_d = out_iter_q;
    mem_req_o  = '0;

    // Fold returning row data: keep the first column holding the maximum
    if (scan_vld_q && ((scan_col_q == '0) || (mem_rdata_i > best_q))) begin
      best_d     = mem_rdata_i;
      best_col_d = scan_col_q;
    end

    unique case (state_q)
      // Load one element per item; the last one launches the search
      S_IDLE: begin
        if (start) begin
          if ((2*DimW)'(ptr_q) < total) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ptr_q[AddrW-1:0];
            mem_req_o.wdata = element_value_i;
            ptr_d           = ptr_q + PtrW'(1);
          end
          if (last_element_i) begin
            lo_d    = '0;
            hi_d    = RowW'(dims_i.rows - DimW'(1));
            iter_d  = '0;
            ptr_d   = '0;
            state_d = S_MID;
          end
        end
      end
      // Pick the middle row and its base address
      S_MID: begin
        mid_d   = bound_sum[RowW:1];
        base_d  = base_prod[AddrW-1:0];
        col_d   = '0;
        state_d = S_SCAN;
      end
      // Stream the row out of the store
      S_SCAN: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = base_q + AddrW'(col_q);
        scan_vld_d      = 1'b1;
        scan_col_d      = col_q;
        if (DimW'(col_q) == dims_i.cols - DimW'(1)) begin
          state_d = S_LAST;
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
      // Last row element folds in here
      S_LAST: begin
        state_d = S_UP;
      end
      // Neighbor above
      S_UP: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = base_q - AddrW'(dims_i.cols) + AddrW'(best_col_q);
        state_d         = S_DN;
      end
      // Neighbor below; above value returns
      S_DN: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = base_q + AddrW'(dims_i.cols) + AddrW'(best_col_q);
        up_win_d        = (mid_q != '0) && (mem_rdata_i > best_q);
        win_d           = up_win_d ? mem_rdata_i : best_q;
        state_d         = S_DEC;
      end
      // Below value returns: move or stop
      S_DEC: begin
        iter_d = iter_q + IterW'(1);
        if (!dn_win && up_win_q && (mid_q > lo_q)) begin
          hi_d    = mid_q - RowW'(1);
          state_d = S_MID;
        end else if (dn_win && (mid_q < hi_q)) begin
          lo_d    = mid_q + RowW'(1);
          state_d = S_MID;
        end else begin
          done_d     = 1'b1;
          out_row_d  = mid_q;
          out_col_d  = best_col_q;
          out_iter_d = iter_q + IterW'(1);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      base_q     <= '0;
      col_q      <= '0;
      scan_vld_q <= 1'b0;
      scan_col_q <= '0;
      best_q     <= '0;
      best_col_q <= '0;
      up_win_q   <= 1'b0;
      win_q      <= '0;
      iter_q     <= '0;
      done_q     <= 1'b0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_iter_q <= '0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      mid_q      <= mid_d;
      base_q     <= base_d;
      col_q      <= col_d;
      scan_vld_q <= scan_vld_d;
      scan_col_q <= scan_col_d;
      best_q     <= best_d;
      best_col_q <= best_col_d;
      up_win_q   <= up_win_d;
      win_q      <= win_d;
      iter_q     <= iter_d;
      done_q     <= done_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_iter_q <= out_iter_d;
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign peak_row_o        = out_row_q;
  assign peak_col_o        = out_col_q;
  assign iteration_count_o = out_iter_q;

  // Checks
  a_done_after_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_DEC))
    else $error("result strobe without a final decision");

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_IDLE))
    else $error("store written during search");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (lo_q <= hi_q))
    else $error("row bounds crossed");

  a_scan_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (DimW'(col_q) < dims_i.cols))
    else $error("row scan past last column");

  a_ptr_reset_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (ptr_q == '0))
    else $error("load pointer not rewound after search");

endmodule

/* rtl/matrix_peak_finder_2d.sv */
// ----------------------------------------------------------------------------
// matrix_peak_finder_2d
// Loads a matrix row-major into a block RAM and finds a 2-D peak by
// row halving: per step, the row maximum is checked against its neighbors.
// ----------------------------------------------------------------------------
// Load: one item per cycle, busy stays low while elements stream in.
// Search: starts after the last item; each halving step makes one store
//   read per column and two neighbor reads, plus bookkeeping; there are
//   at most 7 steps at 64 rows; the result strobe follows the last step.
// The receiver cannot stall: done_o is high for exactly one cycle.
// Reset clears control state and sets both dimensions to 64; the matrix
//   store is not cleared and holds whatever it held.
module matrix_peak_finder_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mpf_pkg::DataW-1:0]      element_value_i,
  input  logic                           last_element_i,
  input  logic                           cfg_we_i,
  input  logic [mpf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mpf_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           done_o,
  output logic [mpf_pkg::RowW-1:0]       peak_row_o,
  output logic [mpf_pkg::ColW-1:0]       peak_col_o,
  output logic [mpf_pkg::IterW-1:0]      iteration_count_o
);
  import mpf_pkg::*;

  logic [DimW-1:0] num_rows_q, num_rows_d;
  logic [DimW-1:0] num_cols_q, num_cols_d;
  dims_t           dims;
  mem_req_t        mem_req;
  logic [DataW-1:0] mem_rdata;

  // Configuration registers
  always_comb begin
    num_rows_d = num_rows_q;
    num_cols_d = num_cols_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumRows: num_rows_d = cfg_data_i;
        CfgNumCols: num_cols_d = cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DimResetVal;
      num_cols_q <= DimResetVal;
    end else begin
      num_rows_q <= num_rows_d;
      num_cols_q <= num_cols_d;
    end
  end

  // Effective dimensions
  assign dims.rows = clamp_dim(num_rows_q, DimW'(MaxRows));
  assign dims.cols = clamp_dim(num_cols_q, DimW'(MaxCols));

  // Search engine
  mpf_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .element_value_i   (element_value_i),
    .last_element_i    (last_element_i),
    .dims_i            (dims),
    .mem_req_o         (mem_req),
    .mem_rdata_i       (mem_rdata),
    .done_o            (done_o),
    .peak_row_o        (peak_row_o),
    .peak_col_o        (peak_col_o),
    .iteration_count_o (iteration_count_o)
  );

  // Matrix store
  mpf_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
